>>> rtl/core/lea128bd_pkg.sv
// ----------------------------------------------------------------------------
// LEA-128 block decrypt package
// Shared widths, item type, key select codes and word helpers for the
// pipelined LEA-128 decrypt unit.
// ----------------------------------------------------------------------------
package lea128bd_pkg;

  localparam int unsigned ROUND_COUNT         = 24;
  localparam int unsigned KEY_WORDS_PER_ROUND = 4;
  localparam int unsigned WORD_W              = 32;
  localparam int unsigned LANES               = 4;
  localparam int unsigned KEY_IDX_W           = 7;
  localparam int unsigned KEY_SEL_W           = $clog2(KEY_WORDS_PER_ROUND);
  localparam int unsigned GROUP_W             = KEY_IDX_W - KEY_SEL_W;

  // Rotation amounts of the three updated lanes
  localparam int unsigned ROT_R_LANE1 = 9;
  localparam int unsigned ROT_L_LANE2 = 5;
  localparam int unsigned ROT_L_LANE3 = 3;

  typedef logic [WORD_W-1:0]    word_t;
  typedef word_t [LANES-1:0]    block_t;
  typedef logic [KEY_SEL_W-1:0] key_sel_t;
  typedef logic [GROUP_W-1:0]   group_t;

  // Action codes
  localparam logic ACTION_KEY_LOAD = 1'b0;
  localparam logic ACTION_DECRYPT  = 1'b1;

  // Position of a word inside its round-key group
  localparam key_sel_t KSEL_K0 = key_sel_t'(0);
  localparam key_sel_t KSEL_K1 = key_sel_t'(1);
  localparam key_sel_t KSEL_K2 = key_sel_t'(2);
  localparam key_sel_t KSEL_K3 = key_sel_t'(3);

  // One pipeline word: either a key load or a block in flight
  typedef struct packed {
    logic                 action;
    logic [KEY_IDX_W-1:0] key_index;
    word_t                key_word;
    block_t               blk;
  } item_t;

  function automatic word_t swap_bytes(input word_t v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic word_t rot_left(input word_t v, input int unsigned n);
    rot_left = (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic word_t rot_right(input word_t v, input int unsigned n);
    rot_right = (v >> n) | (v << (WORD_W - n));
  endfunction

endpackage

>>> rtl/core/lea128bd_round.sv
// ----------------------------------------------------------------------------
// LEA-128 decrypt round
// One decryption round split into three register stages, one lane update
// each. Every stage keeps its own copy of the round-key words it uses and
// updates that copy when a key-load word passes it, so words keep order.
// ----------------------------------------------------------------------------
module lea128bd_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lea128bd_pkg::group_t  group_i,
  input  logic                  in_valid_i,
  input  lea128bd_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  output lea128bd_pkg::item_t   out_item_o
);

  // Stage registers
  logic                a_valid_q, b_valid_q, c_valid_q;
  lea128bd_pkg::item_t a_item_q, b_item_q, c_item_q;
  lea128bd_pkg::item_t a_item_d, b_item_d, c_item_d;

  // Per-stage round-key copies
  lea128bd_pkg::word_t a_k0_q, a_k1_q;
  lea128bd_pkg::word_t b_k2_q, b_k1_q;
  lea128bd_pkg::word_t c_k3_q, c_k1_q;

  logic                   a_hit, b_hit, c_hit;
  lea128bd_pkg::key_sel_t a_sel, b_sel, c_sel;

  // Detect key-load words for this round's group entering each stage
  assign a_hit = en_i && in_valid_i && (in_item_i.action == lea128bd_pkg::ACTION_KEY_LOAD)
              && (in_item_i.key_index[lea128bd_pkg::KEY_IDX_W-1:lea128bd_pkg::KEY_SEL_W]
                  == group_i);
  assign b_hit = en_i && a_valid_q && (a_item_q.action == lea128bd_pkg::ACTION_KEY_LOAD)
              && (a_item_q.key_index[lea128bd_pkg::KEY_IDX_W-1:lea128bd_pkg::KEY_SEL_W]
                  == group_i);
  assign c_hit = en_i && b_valid_q && (b_item_q.action == lea128bd_pkg::ACTION_KEY_LOAD)
              && (b_item_q.key_index[lea128bd_pkg::KEY_IDX_W-1:lea128bd_pkg::KEY_SEL_W]
                  == group_i);

  assign a_sel = in_item_i.key_index[lea128bd_pkg::KEY_SEL_W-1:0];
  assign b_sel = a_item_q.key_index[lea128bd_pkg::KEY_SEL_W-1:0];
  assign c_sel = b_item_q.key_index[lea128bd_pkg::KEY_SEL_W-1:0];

  // Update key copies as key-load words pass
  always_ff @(posedge clk_i) begin
    if (a_hit && (a_sel == lea128bd_pkg::KSEL_K0)) a_k0_q <= in_item_i.key_word;
    if (a_hit && (a_sel == lea128bd_pkg::KSEL_K1)) a_k1_q <= in_item_i.key_word;
    if (b_hit && (b_sel == lea128bd_pkg::KSEL_K2)) b_k2_q <= a_item_q.key_word;
    if (b_hit && (b_sel == lea128bd_pkg::KSEL_K1)) b_k1_q <= a_item_q.key_word;
    if (c_hit && (c_sel == lea128bd_pkg::KSEL_K3)) c_k3_q <= b_item_q.key_word;
    if (c_hit && (c_sel == lea128bd_pkg::KSEL_K1)) c_k1_q <= b_item_q.key_word;
  end

  // Stage A: new lane 0 is old lane 3, compute new lane 1
  // Lanes leave as {x3, y1, x1, x2}
  always_comb begin
    a_item_d        = in_item_i;
    a_item_d.blk[0] = in_item_i.blk[3];
    a_item_d.blk[1] = (lea128bd_pkg::rot_right(in_item_i.blk[0], lea128bd_pkg::ROT_R_LANE1)
                       - (in_item_i.blk[3] ^ a_k0_q)) ^ a_k1_q;
    a_item_d.blk[2] = in_item_i.blk[1];
    a_item_d.blk[3] = in_item_i.blk[2];
  end

  // Stage B: compute new lane 2 from x1 and y1
  always_comb begin
    b_item_d        = a_item_q;
    b_item_d.blk[2] = (lea128bd_pkg::rot_left(a_item_q.blk[2], lea128bd_pkg::ROT_L_LANE2)
                       - (a_item_q.blk[1] ^ b_k2_q)) ^ b_k1_q;
  end

  // Stage C: compute new lane 3 from x2 and y2
  always_comb begin
    c_item_d        = b_item_q;
    c_item_d.blk[3] = (lea128bd_pkg::rot_left(b_item_q.blk[3], lea128bd_pkg::ROT_L_LANE3)
                       - (b_item_q.blk[2] ^ c_k3_q)) ^ c_k1_q;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q <= a_item_d;
      b_item_q <= b_item_d;
      c_item_q <= c_item_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_item_o  = c_item_q;

endmodule

>>> rtl/core/lea128_block_decrypt_unit.sv
// An accepted decrypt word passes the three register stages of every round, then the output register, to out_valid_o.
// Throughput: one word per cycle while in_stall_o is low; each round is three register stages, one lane each.
// Key loads travel the pipeline in order and produce no output word.
// A two-entry output buffer holds results; in_stall_o rises only when both are full.
// Reset clears all valid bits asynchronously; round-key registers are not reset.
// ----------------------------------------------------------------------------
// LEA-128 block decrypt unit
// Fully pipelined LEA-128 decryption with round keys loaded through the
// input channel and held next to the round stages that use them.
// ----------------------------------------------------------------------------
module lea128_block_decrypt_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    action_i,
  input  logic [lea128bd_pkg::KEY_IDX_W-1:0]      key_index_i,
  input  lea128bd_pkg::word_t                     key_word_i,
  input  lea128bd_pkg::word_t                     cipher_word_0_i,
  input  lea128bd_pkg::word_t                     cipher_word_1_i,
  input  lea128bd_pkg::word_t                     cipher_word_2_i,
  input  lea128bd_pkg::word_t                     cipher_word_3_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output lea128bd_pkg::word_t                     plain_word_0_o,
  output lea128bd_pkg::word_t                     plain_word_1_o,
  output lea128bd_pkg::word_t                     plain_word_2_o,
  output lea128bd_pkg::word_t                     plain_word_3_o
);

  logic                 en;
  logic                 stage_valid [lea128bd_pkg::ROUND_COUNT+1];
  lea128bd_pkg::item_t  stage_item  [lea128bd_pkg::ROUND_COUNT+1];

  logic                 res_valid;
  lea128bd_pkg::block_t res_blk;
  logic                 out_free;

  logic                 out_valid_q, skid_valid_q;
  lea128bd_pkg::block_t out_blk_q, skid_blk_q;

  // Pipeline moves whenever the skid entry is empty
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Build entry word, byte-swapping the cipher lanes
  assign stage_valid[0]            = in_valid_i;
  assign stage_item[0].action      = action_i;
  assign stage_item[0].key_index   = key_index_i;
  assign stage_item[0].key_word    = key_word_i;
  assign stage_item[0].blk[0]      = lea128bd_pkg::swap_bytes(cipher_word_0_i);
  assign stage_item[0].blk[1]      = lea128bd_pkg::swap_bytes(cipher_word_1_i);
  assign stage_item[0].blk[2]      = lea128bd_pkg::swap_bytes(cipher_word_2_i);
  assign stage_item[0].blk[3]      = lea128bd_pkg::swap_bytes(cipher_word_3_i);

  // Round chain: last key group first
  for (genvar r = 0; r < lea128bd_pkg::ROUND_COUNT; r++) begin : g_round
    lea128bd_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .group_i     (lea128bd_pkg::group_t'(lea128bd_pkg::ROUND_COUNT - 1 - r)),
      .in_valid_i  (stage_valid[r]),
      .in_item_i   (stage_item[r]),
      .out_valid_o (stage_valid[r+1]),
      .out_item_o  (stage_item[r+1])
    );
  end

  // Drop key loads at the tail, byte-swap decrypted lanes
  assign res_valid = en && stage_valid[lea128bd_pkg::ROUND_COUNT]
                  && (stage_item[lea128bd_pkg::ROUND_COUNT].action
                      == lea128bd_pkg::ACTION_DECRYPT);
  for (genvar j = 0; j < lea128bd_pkg::LANES; j++) begin : g_swap
    assign res_blk[j] = lea128bd_pkg::swap_bytes(stage_item[lea128bd_pkg::ROUND_COUNT].blk[j]);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Output register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid entry payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_blk_q <= skid_valid_q ? skid_blk_q : res_blk;
    end else if (res_valid) begin
      skid_blk_q <= res_blk;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plain_word_0_o = out_blk_q[0];
  assign plain_word_1_o = out_blk_q[1];
  assign plain_word_2_o = out_blk_q[2];
  assign plain_word_3_o = out_blk_q[3];

endmodule

>>> tb/tb_lea128_block_decrypt_unit.sv
// ----------------------------------------------------------------------------
// LEA-128 block decrypt unit testbench
// Loads the round-key store through the input channel and streams key loads
// and ciphertext blocks with random gaps and output stalls. A scoreboard
// keeps its own key store, predicts each plaintext block on acceptance and
// checks every output word in order.
// ----------------------------------------------------------------------------
module tb_lea128_block_decrypt_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH =
    lea128bd_pkg::ROUND_COUNT * lea128bd_pkg::KEY_WORDS_PER_ROUND;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned REPORT_LIMIT = 10;

  // Track the key store and the plaintext blocks still owed by the unit
  class decrypt_scoreboard;
    lea128bd_pkg::word_t  key_store[STORE_DEPTH];
    lea128bd_pkg::block_t plain_q[$];
    int unsigned          errors;

    function lea128bd_pkg::word_t rotl(lea128bd_pkg::word_t v, int unsigned n);
      logic [2*lea128bd_pkg::WORD_W-1:0] twice;
      twice = {v, v} << n;
      return twice[2*lea128bd_pkg::WORD_W-1:lea128bd_pkg::WORD_W];
    endfunction

    function lea128bd_pkg::word_t rotr(lea128bd_pkg::word_t v, int unsigned n);
      return rotl(v, lea128bd_pkg::WORD_W - n);
    endfunction

    function lea128bd_pkg::word_t byte_rev(lea128bd_pkg::word_t v);
      lea128bd_pkg::word_t r;
      for (int b = 0; b < 4; b++) r[8*b +: 8] = v[8*(3-b) +: 8];
      return r;
    endfunction

    // Run the decryption rounds from the last key group down to group 0
    function lea128bd_pkg::block_t decrypt(lea128bd_pkg::block_t cipher);
      lea128bd_pkg::word_t  x[lea128bd_pkg::LANES];
      lea128bd_pkg::word_t  y0, y1, y2, y3;
      lea128bd_pkg::word_t  k0, k1, k2, k3;
      lea128bd_pkg::block_t plain;
      int                   base;
      for (int j = 0; j < lea128bd_pkg::LANES; j++) x[j] = byte_rev(cipher[j]);
      for (int r = lea128bd_pkg::ROUND_COUNT - 1; r >= 0; r--) begin
        base = r * lea128bd_pkg::KEY_WORDS_PER_ROUND;
        k0 = key_store[base + lea128bd_pkg::KSEL_K0];
        k1 = key_store[base + lea128bd_pkg::KSEL_K1];
        k2 = key_store[base + lea128bd_pkg::KSEL_K2];
        k3 = key_store[base + lea128bd_pkg::KSEL_K3];
        y0 = x[3];
        y1 = (rotr(x[0], lea128bd_pkg::ROT_R_LANE1) - (y0 ^ k0)) ^ k1;
        y2 = (rotl(x[1], lea128bd_pkg::ROT_L_LANE2) - (y1 ^ k2)) ^ k1;
        y3 = (rotl(x[2], lea128bd_pkg::ROT_L_LANE3) - (y2 ^ k3)) ^ k1;
        x[0] = y0;
        x[1] = y1;
        x[2] = y2;
        x[3] = y3;
      end
      for (int j = 0; j < lea128bd_pkg::LANES; j++) plain[j] = byte_rev(x[j]);
      return plain;
    endfunction

    // Apply a key load, or queue the plaintext a decrypt must produce
    function void note_input(logic action, logic [lea128bd_pkg::KEY_IDX_W-1:0] index,
                             lea128bd_pkg::word_t kw, lea128bd_pkg::block_t cipher);
      if (action == lea128bd_pkg::ACTION_KEY_LOAD) begin
        if (index < STORE_DEPTH) key_store[index] = kw;
      end else begin
        plain_q.push_back(decrypt(cipher));
      end
    endfunction

    // Compare one output word with the oldest predicted block
    function void check_result(lea128bd_pkg::block_t got);
      lea128bd_pkg::block_t want;
      if (plain_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected output block %h", got);
        return;
      end
      want = plain_q.pop_front();
      for (int j = 0; j < lea128bd_pkg::LANES; j++) begin
        if (got[j] !== want[j]) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("plain_word_%0d mismatch: expected %08h, got %08h", j, want[j], got[j]);
        end
      end
    endfunction

    function int unsigned pending();
      return plain_q.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               action_i;
  logic [lea128bd_pkg::KEY_IDX_W-1:0] key_index_i;
  lea128bd_pkg::word_t                key_word_i;
  lea128bd_pkg::word_t                cipher_word_0_i;
  lea128bd_pkg::word_t                cipher_word_1_i;
  lea128bd_pkg::word_t                cipher_word_2_i;
  lea128bd_pkg::word_t                cipher_word_3_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  lea128bd_pkg::word_t                plain_word_0_o;
  lea128bd_pkg::word_t                plain_word_1_o;
  lea128bd_pkg::word_t                plain_word_2_o;
  lea128bd_pkg::word_t                plain_word_3_o;

  decrypt_scoreboard sb = new();
  int unsigned       sent_cnt;
  int unsigned       recv_cnt;

  lea128_block_decrypt_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .key_index_i     (key_index_i),
    .key_word_i      (key_word_i),
    .cipher_word_0_i (cipher_word_0_i),
    .cipher_word_1_i (cipher_word_1_i),
    .cipher_word_2_i (cipher_word_2_i),
    .cipher_word_3_i (cipher_word_3_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .plain_word_0_o  (plain_word_0_o),
    .plain_word_1_o  (plain_word_1_o),
    .plain_word_2_o  (plain_word_2_o),
    .plain_word_3_o  (plain_word_3_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Favor the extremes of a word now and then
  function automatic lea128bd_pkg::word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic lea128bd_pkg::block_t rand_block();
    lea128bd_pkg::block_t b;
    for (int j = 0; j < lea128bd_pkg::LANES; j++) b[j] = rand_word();
    return b;
  endfunction

  // Drive one input word after a random gap and hold it until accepted
  task automatic send_word(logic action, logic [lea128bd_pkg::KEY_IDX_W-1:0] index,
                           lea128bd_pkg::word_t kw, lea128bd_pkg::block_t cipher);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if ((sent_cnt / 60) % 4 == 2) gap = 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    action_i        = action;
    key_index_i     = index;
    key_word_i      = kw;
    cipher_word_0_i = cipher[0];
    cipher_word_1_i = cipher[1];
    cipher_word_2_i = cipher[2];
    cipher_word_3_i = cipher[3];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(action, index, kw, cipher);
    sent_cnt++;
  endtask

  // Key load with random ciphertext, which the unit must ignore
  task automatic load_key(logic [lea128bd_pkg::KEY_IDX_W-1:0] index,
                          lea128bd_pkg::word_t kw);
    send_word(lea128bd_pkg::ACTION_KEY_LOAD, index, kw, rand_block());
  endtask

  // Decrypt with random key fields, which the unit must ignore
  task automatic decrypt_word(lea128bd_pkg::block_t cipher);
    send_word(lea128bd_pkg::ACTION_DECRYPT, lea128bd_pkg::KEY_IDX_W'($urandom), $urandom,
              cipher);
  endtask

  // Drop valid and hold the sender until every predicted block has come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Stall the output for a random number of cycles before each word
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(0, 9);
      if ((recv_cnt / 50) % 4 == 1) hold = 0;
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({plain_word_3_o, plain_word_2_o, plain_word_1_o, plain_word_0_o});
      recv_cnt++;
    end
  end

  initial begin
    int unsigned pick;
    in_valid_i      = 1'b0;
    action_i        = lea128bd_pkg::ACTION_KEY_LOAD;
    key_index_i     = '0;
    key_word_i      = '0;
    cipher_word_0_i = '0;
    cipher_word_1_i = '0;
    cipher_word_2_i = '0;
    cipher_word_3_i = '0;
    sent_cnt        = 0;
    recv_cnt        = 0;
    rst_ni          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // All-zero round keys, then extreme blocks
    for (int i = 0; i < STORE_DEPTH; i++) load_key(lea128bd_pkg::KEY_IDX_W'(i), '0);
    decrypt_word('0);
    decrypt_word('1);

    // All-ones round keys, then extreme and alternating blocks
    for (int i = 0; i < STORE_DEPTH; i++) load_key(lea128bd_pkg::KEY_IDX_W'(i), '1);
    decrypt_word('0);
    decrypt_word('1);
    decrypt_word({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});

    // Loads past the store depth must leave the keys untouched
    load_key(lea128bd_pkg::KEY_IDX_W'(STORE_DEPTH), $urandom);
    load_key('1, $urandom);
    decrypt_word(rand_block());

    // Random round keys
    for (int i = 0; i < STORE_DEPTH; i++) load_key(lea128bd_pkg::KEY_IDX_W'(i), $urandom);
    decrypt_word(rand_block());
    decrypt_word(rand_block());
    drain();

    // Mixed stream: mostly decrypts, key updates in flight, some ignored loads
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 55)
        decrypt_word(rand_block());
      else if (pick < 90)
        load_key(lea128bd_pkg::KEY_IDX_W'($urandom_range(0, STORE_DEPTH - 1)), rand_word());
      else
        load_key(lea128bd_pkg::KEY_IDX_W'($urandom_range(STORE_DEPTH,
                                                          2**lea128bd_pkg::KEY_IDX_W - 1)),
                 rand_word());
    end

    // Release the input and let the pipeline empty
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();
    repeat (3 * lea128bd_pkg::ROUND_COUNT + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lea128_block_decrypt_unit test passed");
    end else begin
      $display("lea128_block_decrypt_unit test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1000000;
    $display("lea128_block_decrypt_unit test failed");
    $finish;
  end

endmodule

>>> lea128_block_decrypt_unit.f
rtl/core/lea128bd_pkg.sv
rtl/core/lea128bd_round.sv
rtl/core/lea128_block_decrypt_unit.sv
tb/tb_lea128_block_decrypt_unit.sv
